// ----- hw/rtl/tlnef_pkg.sv -----
// Shared types and constants for the text line number and escape filter.
// No dependencies; imported by every module of the block.
package tlnef_pkg;

   localparam int NUMBER_DIGITS   = 6;
   localparam int CAP_DIGITS      = (NUMBER_DIGITS < 6) ? NUMBER_DIGITS : 6;
   localparam int MAX_RESULTS     = NUMBER_DIGITS + 3;
   localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);

   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_ENDS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING = 3'd4;

   localparam logic [1:0] NUM_MODE_ALL = 2'd1;

   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_LF       = 8'd10;
   localparam logic [7:0] CHAR_SPACE    = 8'd32;
   localparam logic [7:0] CHAR_DOLLAR   = 8'd36;
   localparam logic [7:0] CHAR_ZERO     = 8'd48;
   localparam logic [7:0] CHAR_QUESTION = 8'd63;
   localparam logic [7:0] CHAR_I        = 8'd73;
   localparam logic [7:0] CHAR_CARET    = 8'd94;
   localparam logic [7:0] CHAR_DEL      = 8'd127;
   localparam logic [7:0] CTRL_LIMIT    = 8'd32;
   localparam logic [7:0] CARET_OFFSET  = 8'd64;

   localparam logic [3:0] DIGIT_NINE    = 4'd9;

   typedef logic [NUMBER_DIGITS-1:0][3:0] digit_array_type;
   typedef logic [MAX_RESULTS-1:0][7:0]   char_array_type;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       show_ends;
      logic       show_tabs;
      logic       show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic at_line_start;
      logic prev_line_blank;
   } line_state_type;

   typedef struct packed {
      char_array_type       chars;
      logic [COUNT_W-1:0]   count;
   } plan_type;

endpackage

// ----- hw/rtl/tlnef_line_counter.sv -----
// Decimal line counter held as digits, with restart and saturation.
// Depends on tlnef_pkg.
module tlnef_line_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic                      commit,
   input  logic                      advance,
   output tlnef_pkg::digit_array_type digits
);
   import tlnef_pkg::*;

   digit_array_type digits_ff, digits_in;
   digit_array_type one_digits;
   digit_array_type inc_digits;
   logic            saturated;
   logic            carry;

   always_comb begin
      one_digits = '0;
      one_digits[NUMBER_DIGITS-1] = 4'd1;
   end

   // digit index 0 is the most significant column
   assign digits = restart ? one_digits : digits_ff;

   always_comb begin
      saturated = 1'b1;
      for (int i = NUMBER_DIGITS - CAP_DIGITS; i < NUMBER_DIGITS; i++) begin
         if (digits[i] != DIGIT_NINE) begin
            saturated = 1'b0;
         end
      end
   end

   always_comb begin
      carry      = 1'b1;
      inc_digits = digits;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         if (carry) begin
            if (digits[i] == DIGIT_NINE) begin
               inc_digits[i] = 4'd0;
            end else begin
               inc_digits[i] = digits[i] + 4'd1;
               carry         = 1'b0;
            end
         end
      end
   end

   always_comb begin
      digits_in = digits_ff;
      if (commit) begin
         digits_in = (advance && !saturated) ? inc_digits : digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= one_digits;
      end else begin
         digits_ff <= digits_in;
      end
   end

endmodule

// ----- hw/rtl/tlnef_format.sv -----
// Character planner: turns one byte and the line state into its output characters.
// Depends on tlnef_pkg.
module tlnef_format (
   input  tlnef_pkg::cfg_type         cfg,
   input  logic [7:0]                 byte_value,
   input  logic                       file_start,
   input  tlnef_pkg::line_state_type  state_cur,
   input  tlnef_pkg::digit_array_type digits,
   output tlnef_pkg::line_state_type  state_next,
   output logic                       advance,
   output tlnef_pkg::plan_type        plan
);
   import tlnef_pkg::*;

   logic                 als;
   logic                 plb;
   logic                 blank;
   logic                 squeeze;
   logic                 number;
   logic                 seen;
   logic [7:0]           body0;
   logic [7:0]           body1;
   logic [COUNT_W-1:0]   body_cnt;
   logic [NUMBER_DIGITS-1:0][7:0] text;

   assign als     = file_start | state_cur.at_line_start;
   assign plb     = !file_start & state_cur.prev_line_blank;
   assign blank   = (byte_value == CHAR_LF);
   assign squeeze = als && cfg.squeeze_blank && blank && plb;
   assign number  = als && !squeeze &&
                    ((cfg.number_mode == NUM_MODE_ALL) || (cfg.number_mode[1] && !blank));
   assign advance = number;

   always_comb begin
      if (squeeze) begin
         state_next.at_line_start   = als;
         state_next.prev_line_blank = plb;
      end else begin
         state_next.at_line_start   = blank;
         state_next.prev_line_blank = als ? blank : plb;
      end
   end

   // right-aligned number: leading zeros become spaces, units always shown
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         seen = seen | (digits[i] != 4'd0);
         if (!seen && (i != NUMBER_DIGITS - 1)) begin
            text[i] = CHAR_SPACE;
         end else begin
            text[i] = CHAR_ZERO | {4'd0, digits[i]};
         end
      end
   end

   always_comb begin
      body0    = byte_value;
      body1    = 8'd0;
      body_cnt = COUNT_W'(1);
      priority if (blank) begin
         if (cfg.show_ends) begin
            body0    = CHAR_DOLLAR;
            body1    = CHAR_LF;
            body_cnt = COUNT_W'(2);
         end
      end else if (cfg.show_tabs && byte_value == CHAR_TAB) begin
         body0    = CHAR_CARET;
         body1    = CHAR_I;
         body_cnt = COUNT_W'(2);
      end else if (cfg.show_nonprinting && byte_value < CTRL_LIMIT
                   && byte_value != CHAR_TAB) begin
         body0    = CHAR_CARET;
         body1    = byte_value + CARET_OFFSET;
         body_cnt = COUNT_W'(2);
      end else if (cfg.show_nonprinting && byte_value == CHAR_DEL) begin
         body0    = CHAR_CARET;
         body1    = CHAR_QUESTION;
         body_cnt = COUNT_W'(2);
      end else begin
         // pass any other byte through as it is
      end
   end

   always_comb begin
      plan.chars = '0;
      if (number) begin
         for (int i = 0; i < NUMBER_DIGITS; i++) begin
            plan.chars[i] = text[i];
         end
         plan.chars[NUMBER_DIGITS]     = CHAR_TAB;
         plan.chars[NUMBER_DIGITS + 1] = body0;
         plan.chars[NUMBER_DIGITS + 2] = body1;
      end else begin
         plan.chars[0] = body0;
         plan.chars[1] = body1;
      end
      if (squeeze) begin
         plan.count = '0;
      end else if (number) begin
         plan.count = COUNT_W'(NUMBER_DIGITS + 1) + body_cnt;
      end else begin
         plan.count = body_cnt;
      end
   end

endmodule

// ----- hw/rtl/tlnef_emit_buffer.sv -----
// Output shift buffer: holds the characters of one item and hands them out in order.
// Depends on tlnef_pkg.
module tlnef_emit_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tlnef_pkg::plan_type plan,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_of_run
);
   import tlnef_pkg::*;

   char_array_type      chars_ff, chars_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                take;

   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_char    = chars_ff[0];
   assign rsp_last_of_run = (count_ff == COUNT_W'(1));
   assign take            = rsp_valid && !rsp_stall;
   assign can_load        = (count_ff == '0) || (rsp_last_of_run && take);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load) begin
         chars_in = plan.chars;
         count_in = plan.count;
      end else if (take) begin
         for (int k = 0; k < MAX_RESULTS - 1; k++) begin
            chars_in[k] = chars_ff[k + 1];
         end
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

endmodule

// ----- hw/rtl/text_line_number_and_escape_filter_core.sv -----
// Text line number and escape filter, top level. Uses tlnef_pkg and its submodules.
// Each accepted item waits in the input register; its plan then loads the emit
// buffer. Throughput: one item per cycle when each yields one character and the
// output does not stall, else one character per unstalled cycle (a numbered line
// yields up to NUMBER_DIGITS+3), set by the single-character result port.
// Reset: synchronous, clears configuration and valid state to zero, line state to line start, count to 1.
module text_line_number_and_escape_filter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [tlnef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlnef_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_byte_value,
   input  logic                             req_file_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_char,
   output logic                             rsp_last_of_run
);
   import tlnef_pkg::*;

   // configuration registers
   cfg_type        cfg_ff, cfg_in;

   // input register: holds one item until the emit buffer can take its plan
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           in_file_start_ff, in_file_start_in;

   // line state carried between items
   line_state_type line_ff, line_in;
   line_state_type line_next;

   digit_array_type digits;
   plan_type        plan;
   logic            advance;
   logic            can_load;
   logic            load;
   logic            accept;

   // plan the held item whenever the buffer is empty or its last character is being taken
   assign load      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NUMBER_MODE:      cfg_in.number_mode      = csr_data;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_data[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_data[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_data[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_data[0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // advance the input register: refill on accept, empty once planned
   always_comb begin
      in_valid_in      = in_valid_ff;
      in_byte_in       = in_byte_ff;
      in_file_start_in = in_file_start_ff;
      if (accept) begin
         in_valid_in      = 1'b1;
         in_byte_in       = req_byte_value;
         in_file_start_in = req_file_start;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // commit the line state only when the item's plan goes to the buffer
   assign line_in = load ? line_next : line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         in_valid_ff           <= 1'b0;
         line_ff.at_line_start <= 1'b1;
         line_ff.prev_line_blank <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         line_ff     <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff       <= in_byte_in;
      in_file_start_ff <= in_file_start_in;
   end

   // decimal line counter; a file start restarts it at one before this item
   tlnef_line_counter u_counter (
      .clock   (clock),
      .reset   (reset),
      .restart (in_file_start_ff),
      .commit  (load),
      .advance (advance),
      .digits  (digits)
   );

   // work out every character of the held item in one pass
   tlnef_format u_format (
      .cfg        (cfg_ff),
      .byte_value (in_byte_ff),
      .file_start (in_file_start_ff),
      .state_cur  (line_ff),
      .digits     (digits),
      .state_next (line_next),
      .advance    (advance),
      .plan       (plan)
   );

   // hand out the planned characters one per cycle while the receiver does not stall
   tlnef_emit_buffer u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .plan            (plan),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for text_line_number_and_escape_filter_core.
// Depends on tlnef_pkg and the core RTL; carries its own model of the filter and
// checks every emitted character against it.
`timescale 1ns / 100ps

module tb;
   import tlnef_pkg::*;

   localparam int unsigned COUNT_CAP     = 999999;
   localparam int          CYCLE_LIMIT   = 100_000;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          MAX_REPORTS   = 10;
   localparam int          PHASE_ITEMS   = 32;
   localparam int          RANDOM_PHASES = 8;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          PRESSURE_ITEMS = 40;

   // Numbering modes not named in the package
   localparam logic [1:0] NUM_MODE_OFF   = 2'd0;
   localparam logic [1:0] NUM_MODE_TEXT  = 2'd2;
   localparam logic [1:0] NUM_MODE_ALIAS = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
   } out_char_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_style_type;

   // Clock, reset and every block input start at known values
   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   csr_write       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_byte_value  = '0;
   logic                   req_file_start  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [7:0]             rsp_out_char;
   logic                   rsp_last_of_run;

   // Receiver control: a background pattern plus a long hold-off
   stall_style_type stall_style  = STALL_NONE;
   logic         rsp_hold        = 1'b0;
   logic         stall_next;
   int           stall_run_left  = 0;
   logic         stall_run_level = 1'b0;

   // Model state and its copy of the registers
   cfg_type     cfg;
   logic        ln_at_start;
   logic        ln_prev_blank;
   logic [19:0] ln_count;

   out_char_type expected_chars[$];
   out_char_type exp_char;

   int cycle_count      = 0;
   int fail_count       = 0;
   int items_sent       = 0;
   int chars_checked    = 0;
   int settings_applied = 0;

   text_line_number_and_escape_filter_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_file_start  (req_file_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   // Watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Record a failure; report only the first few in full
   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // Largest number the counter may reach: the smaller of the cap and the
   // widest value that fits in the digit columns
   function automatic int unsigned count_cap();
      longint lim;
      int     i;
      lim = 1;
      for (i = 0; i < NUMBER_DIGITS; i++) begin
         lim = lim * 10;
         if (lim > COUNT_CAP) begin
            return COUNT_CAP;
         end
      end
      return int'(lim - 1);
   endfunction

   // Work out the characters one byte causes and queue them, advancing the
   // line state and the counter as the block does
   task automatic filter_byte(input logic [7:0] b, input logic fs);
      logic [7:0]  chars [MAX_RESULTS];
      int          n;
      int          d;
      int          i;
      logic        blank;
      logic [19:0] v;
      n = 0;
      if (fs) begin
         ln_count      = 20'd1;
         ln_at_start   = 1'b1;
         ln_prev_blank = 1'b0;
      end
      if (ln_at_start) begin
         blank = (b == CHAR_LF);
         // A blank line straight after another one vanishes when squeezing
         if (cfg.squeeze_blank && blank && ln_prev_blank) begin
            return;
         end
         ln_prev_blank = blank;
         if (cfg.number_mode == NUM_MODE_ALL ||
             (cfg.number_mode > NUM_MODE_ALL && !blank)) begin
            // Right-align the count, padding with spaces, always at least one digit
            v = ln_count;
            for (d = NUMBER_DIGITS - 1; d >= 0; d--) begin
               if (v != 0 || d == NUMBER_DIGITS - 1) begin
                  chars[d] = CHAR_ZERO + 8'(v % 10);
                  v = v / 10;
               end else begin
                  chars[d] = CHAR_SPACE;
               end
            end
            chars[NUMBER_DIGITS] = CHAR_TAB;
            n = NUMBER_DIGITS + 1;
            if (ln_count < count_cap()) begin
               ln_count = ln_count + 1;
            end
         end
      end
      if (b == CHAR_LF) begin
         if (cfg.show_ends) begin
            chars[n] = CHAR_DOLLAR;
            n++;
         end
         chars[n] = CHAR_LF;
         n++;
         ln_at_start = 1'b1;
      end else begin
         ln_at_start = 1'b0;
         if (cfg.show_tabs && b == CHAR_TAB) begin
            chars[n]     = CHAR_CARET;
            chars[n + 1] = CHAR_I;
            n += 2;
         end else if (cfg.show_nonprinting && b < CTRL_LIMIT && b != CHAR_TAB) begin
            chars[n]     = CHAR_CARET;
            chars[n + 1] = b + CARET_OFFSET;
            n += 2;
         end else if (cfg.show_nonprinting && b == CHAR_DEL) begin
            chars[n]     = CHAR_CARET;
            chars[n + 1] = CHAR_QUESTION;
            n += 2;
         end else begin
            chars[n] = b;
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         expected_chars.push_back('{out_char: chars[i], last_of_run: (i == n - 1)});
      end
   endtask

   // Checker and receiver: compare each taken character with the oldest
   // expectation, then pick the stall level for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            log_failure($sformatf("unexpected character 0x%02h last=%0b",
                                  rsp_out_char, rsp_last_of_run));
         end else begin
            exp_char = expected_chars.pop_front();
            if (rsp_out_char !== exp_char.out_char ||
                rsp_last_of_run !== exp_char.last_of_run) begin
               log_failure($sformatf(
                  "mismatch: char expected 0x%02h got 0x%02h, last expected %0b got %0b",
                  exp_char.out_char, rsp_out_char, exp_char.last_of_run, rsp_last_of_run));
            end
         end
      end
      case (stall_style)
         STALL_NONE: begin
            stall_next = 1'b0;
         end
         STALL_SPARSE: begin
            stall_next = ($urandom_range(0, 3) == 0);
         end
         default: begin
            // Runs of stall and flow of random length
            if (stall_run_left == 0) begin
               stall_run_left  = $urandom_range(1, 8);
               stall_run_level = 1'($urandom_range(0, 1));
            end
            stall_run_left--;
            stall_next = stall_run_level;
         end
      endcase
      rsp_stall <= rsp_hold | stall_next;
   end

   // Write one register and mirror it in the model; the caller drops the enable
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_NUMBER_MODE:      cfg.number_mode      = data[1:0];
         CSR_SQUEEZE_BLANK:    cfg.squeeze_blank    = data[0];
         CSR_SHOW_ENDS:        cfg.show_ends        = data[0];
         CSR_SHOW_TABS:        cfg.show_tabs        = data[0];
         CSR_SHOW_NONPRINTING: cfg.show_nonprinting = data[0];
         default: ;
      endcase
   endtask

   // Program every register; one-bit registers get a random upper data bit,
   // which the block must mask off. Optionally poke the unused indexes too.
   task automatic apply_config(input logic [1:0] mode, input logic sq, input logic ends,
                               input logic tabs, input logic np, input bit poke_unused);
      logic junk;
      int   i;
      write_csr(CSR_NUMBER_MODE, mode);
      junk = 1'($urandom_range(0, 1));
      write_csr(CSR_SQUEEZE_BLANK, {junk, sq});
      junk = 1'($urandom_range(0, 1));
      write_csr(CSR_SHOW_ENDS, {junk, ends});
      junk = 1'($urandom_range(0, 1));
      write_csr(CSR_SHOW_TABS, {junk, tabs});
      junk = 1'($urandom_range(0, 1));
      write_csr(CSR_SHOW_NONPRINTING, {junk, np});
      if (poke_unused) begin
         for (i = CSR_SHOW_NONPRINTING + 1; i <= CSR_INDEX_TOP; i++) begin
            write_csr(i[CSR_INDEX_W-1:0], CSR_DATA_W'($urandom_range(0, 3)));
         end
      end
      csr_write <= 1'b0;
      settings_applied++;
   endtask

   // Offer one item and hold it until the block takes it
   task automatic send_byte(input logic [7:0] b, input logic fs);
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_file_start <= fs;
      do @(posedge clock); while (req_stall);
      filter_byte(b, fs);
      items_sent++;
   endtask

   // Drop valid for a number of cycles
   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid, let every expected character drain, then allow for a
   // squeezed item still in flight
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly text-like bytes: printable runs, line ends and tabs, with some
   // controls, DEL and fully random bytes mixed in
   function automatic logic [7:0] random_text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 8'($urandom_range(32, 126));
      if (pick < 72) return CHAR_LF;
      if (pick < 79) return CHAR_TAB;
      if (pick < 87) return 8'($urandom_range(0, 31));
      if (pick < 91) return CHAR_DEL;
      return 8'($urandom_range(0, 255));
   endfunction

   // Send a stream in bursts of random length, with random gaps between them when gaps are on
   task automatic send_stream(input int count, input bit gaps_on);
      int burst_left;
      int i;
      burst_left = 0;
      for (i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            if (gaps_on) begin
               pause_sender($urandom_range(0, 6));
            end
            burst_left = $urandom_range(1, 16);
         end
         send_byte(random_text_byte(), ($urandom_range(0, 39) == 0));
         burst_left--;
      end
   endtask

   // Caret forms of controls and DEL, high bytes passed through, tab as ^I,
   // dollar before the line end, no numbering
   task automatic test_escapes();
      apply_config(NUM_MODE_OFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      stall_style = STALL_SPARSE;
      send_byte(8'h00, 1'b1);
      send_byte(8'h1F, 1'b0);
      send_byte(CHAR_TAB, 1'b0);
      send_byte(CHAR_DEL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      wait_idle();
   endtask

   // Tab passes raw when only the non-printing option is set; every line numbered
   task automatic test_raw_tab();
      apply_config(NUM_MODE_ALL, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_byte(CHAR_TAB, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(CHAR_DEL, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      wait_idle();
   endtask

   // Mode three numbers text lines only, blank runs collapse, a new file
   // restarts the count and clears the blank history
   task automatic test_squeeze_numbering();
      apply_config(NUM_MODE_ALIAS, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
      stall_style = STALL_RUNS;
      send_byte("x", 1'b1);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte("y", 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_LF, 1'b1);
      send_byte(CHAR_LF, 1'b0);
      wait_idle();
   endtask

   // Random text under a series of settings, the extremes first
   task automatic test_random_text();
      int p;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_config(NUM_MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            1: apply_config(NUM_MODE_TEXT, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            2: apply_config(NUM_MODE_ALIAS, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
            3: apply_config(NUM_MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
            default: apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         // Phase zero runs flat out on both sides
         if (p == 0) begin
            stall_style = STALL_NONE;
         end else begin
            stall_style = stall_style_type'(p % 3);
         end
         send_stream(PHASE_ITEMS, (p != 0));
         wait_idle();
      end
   endtask

   // Hold the receiver off for a long stretch while items keep coming, so
   // the block fills up and stalls its input
   task automatic test_backpressure();
      apply_config(NUM_MODE_ALL, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      stall_style = STALL_NONE;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_stream(PRESSURE_ITEMS, 1'b0);
      join
      wait_idle();
   endtask

   initial begin
      // Model starts from the reset state of the block
      cfg           = '0;
      ln_at_start   = 1'b1;
      ln_prev_blank = 1'b0;
      ln_count      = 20'd1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_escapes();
      test_raw_tab();
      test_squeeze_numbering();
      test_random_text();
      test_backpressure();

      if (expected_chars.size() != 0) begin
         log_failure($sformatf("%0d expected characters never arrived",
                               expected_chars.size()));
      end

      $display("Sent %0d bytes under %0d register settings; checked %0d characters.",
               items_sent, settings_applied, chars_checked);
      $display("Covered escapes, raw tabs, squeezing, numbering modes, file restarts",
               " and a long receiver hold-off.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/tlnef_pkg.sv
hw/rtl/tlnef_line_counter.sv
hw/rtl/tlnef_format.sv
hw/rtl/tlnef_emit_buffer.sv
hw/rtl/text_line_number_and_escape_filter_core.sv
verif/tb.sv
